// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes and result type for the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 31;
  localparam int K_W           = $clog2(PROD_W);
  localparam int CNT_W         = $clog2(PROD_W + 1);
  localparam int IN_FIELDS_W   = 2 + 4 * OPERAND_WIDTH;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((NUM_W + DEN_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             zero_den;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add/sub/mul/div of two signed fractions, reduced by their gcd.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                  | tuser
//  in_     | in  | mode, left_num, left_den, right_num, right_den, pad | -
//  out_    | out | result_num, result_den                              | zero_den
//
// one beat computes the products and reduction checks, then runs a binary gcd
// (one shift or one subtract per step) and two divides on the shared divider;
// a zero numerator or denominator skips these.
// the sequencer takes no new beat until the current one has left it.
// the output register holds a finished result while the next beat is worked.
// rst_n is synchronous; no memory to clear.
module rational_arith_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // mode[1:0], left_num, left_den, right_num, right_den, zero pad
  input  logic [rau_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // result_num[32:0], result_den[63:33]
  output logic [rau_pkg::OUT_TDATA_W-1:0] out_tdata,
  // zero_den
  output logic                           out_tuser
);
  import rau_pkg::*;

  logic core_idle, res_valid, res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  assign in_tready = core_idle;
  assign res_ready = !out_valid_r || out_tready;

  rau_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && core_idle),
    .fields    (in_tdata[IN_FIELDS_W-1:0]),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_r.den, out_r.num});
  assign out_tuser  = out_r.zero_den;

endmodule

// ===== rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rau_pkg::PROD_W-1:0] dividend,
  input  logic [rau_pkg::PROD_W-1:0] divisor,
  output logic [rau_pkg::PROD_W-1:0] quotient,
  output rau_pkg::div_stat_t         stat
);
  import rau_pkg::*;

  logic [PROD_W-1:0] rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [PROD_W:0]   rem_sh;
  logic [PROD_W:0]   trial;

  assign rem_sh = {rem_r, quo_r[PROD_W-1]};
  assign trial  = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        quo_r <= dividend;
        cnt_r <= CNT_W'(PROD_W);
      end else if (cnt_r != '0) begin
        // keep the shifted value when the trial subtract goes negative
        if (!trial[PROD_W]) begin
          rem_r <= trial[PROD_W-1:0];
          quo_r <= {quo_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[PROD_W-1:0];
          quo_r <= {quo_r[PROD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

// ===== rtl/rau_core.sv =====
// ----------------------------------------------------------------------------
// rau_core
// Sequencer: cross products on one multiplier, binary gcd, two divides.
// ----------------------------------------------------------------------------
module rau_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rau_pkg::IN_FIELDS_W-1:0]   fields,
  output logic                              idle,
  output logic                              res_valid,
  input  logic                              res_ready,
  output rau_pkg::res_t                     res
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_GCD,
    S_DIVN, S_WAITN, S_DIVD, S_WAITD, S_DONE
  } state_t;

  state_t            state_r;
  mode_t             mode_r;
  logic [W-1:0]      ln_r, ld_r, rn_r, rd_r;
  logic [PROD_W-1:0] p1_r, p2_r, p3_r;
  logic              s1_r, s2_r, s3_r;
  logic [PROD_W-1:0] num_r, den_r, a_r, b_r, g_r, nm_r, dm_r;
  logic [K_W-1:0]    k_r;
  logic              neg_r, flag_r;

  logic [W-1:0]      lnm, ldm, rnm, rdm;
  logic [W-1:0]      mul_a, mul_b;
  logic              mul_s;
  logic [PROD_W-1:0] prod;
  logic              bneg;
  logic [PROD_W-1:0] sum_mag;
  logic              sum_neg;
  logic              div_start;
  logic [PROD_W-1:0] div_q;
  div_stat_t         div_stat;
  logic [NUM_W-1:0]  nm_ext;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign lnm = mag_of(ln_r);
  assign ldm = mag_of(ld_r);
  assign rnm = mag_of(rn_r);
  assign rdm = mag_of(rd_r);

  // operand routing for the shared multiplier
  always_comb begin
    mul_a = lnm;
    mul_b = rdm;
    mul_s = ln_r[W-1] ^ rd_r[W-1];
    unique case (state_r)
      S_MUL0: begin
        mul_a = lnm;
        mul_b = (mode_r == MODE_MUL) ? rnm : rdm;
        mul_s = ln_r[W-1] ^ ((mode_r == MODE_MUL) ? rn_r[W-1] : rd_r[W-1]);
      end
      S_MUL1: begin
        mul_a = rnm;
        mul_b = ldm;
        mul_s = rn_r[W-1] ^ ld_r[W-1];
      end
      S_MUL2: begin
        mul_a = ldm;
        mul_b = (mode_r == MODE_DIV) ? rnm : rdm;
        mul_s = ld_r[W-1] ^ ((mode_r == MODE_DIV) ? rn_r[W-1] : rd_r[W-1]);
      end
      default: begin
        mul_a = lnm;
        mul_b = rdm;
        mul_s = 1'b0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // signed-magnitude combine of the two cross terms for add/sub; mul and div pass the first product
  always_comb begin
    bneg = s2_r ^ (mode_r == MODE_SUB);
    if (s1_r == bneg) begin
      sum_mag = p1_r + p2_r;
      sum_neg = s1_r;
    end else if (p1_r >= p2_r) begin
      sum_mag = p1_r - p2_r;
      sum_neg = s1_r;
    end else begin
      sum_mag = p2_r - p1_r;
      sum_neg = bneg;
    end
    if (mode_r == MODE_MUL || mode_r == MODE_DIV) begin
      sum_mag = p1_r;
      sum_neg = s1_r;
    end
  end

  assign div_start = (state_r == S_DIVN) || (state_r == S_DIVD);

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ((state_r == S_DIVN) ? num_r : den_r),
    .divisor  (g_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r  <= mode_t'(fields[1:0]);
            ln_r    <= fields[2 +: W];
            ld_r    <= fields[2 + W +: W];
            rn_r    <= fields[2 + 2*W +: W];
            rd_r    <= fields[2 + 3*W +: W];
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          p1_r    <= prod;
          s1_r    <= mul_s;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          p2_r    <= prod;
          s2_r    <= mul_s;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p3_r    <= prod;
          s3_r    <= mul_s;
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r <= sum_mag;
          den_r <= p3_r;
          neg_r <= 1'b0;
          if (p3_r == '0) begin
            flag_r  <= 1'b1;
            nm_r    <= PROD_W'(sum_mag != '0);
            dm_r    <= '0;
            state_r <= S_DONE;
          end else if (sum_mag == '0) begin
            flag_r  <= 1'b0;
            nm_r    <= '0;
            dm_r    <= PROD_W'(1);
            state_r <= S_DONE;
          end else begin
            flag_r  <= 1'b0;
            neg_r   <= sum_neg ^ s3_r;
            a_r     <= sum_mag;
            b_r     <= p3_r;
            k_r     <= '0;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          // binary gcd, one shift or subtract per cycle
          if (!a_r[0] && !b_r[0]) begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!a_r[0]) begin
            a_r <= a_r >> 1;
          end else if (!b_r[0]) begin
            b_r <= b_r >> 1;
          end else if (a_r == b_r) begin
            g_r     <= a_r << k_r;
            state_r <= S_DIVN;
          end else if (a_r > b_r) begin
            a_r <= a_r - b_r;
          end else begin
            b_r <= b_r - a_r;
          end
        end
        S_DIVN: state_r <= S_WAITN;
        S_WAITN: begin
          if (div_stat.done) begin
            nm_r    <= div_q;
            state_r <= S_DIVD;
          end
        end
        S_DIVD: state_r <= S_WAITD;
        S_WAITD: begin
          if (div_stat.done) begin
            dm_r    <= div_q;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign nm_ext       = NUM_W'(nm_r);
  assign idle         = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.num      = neg_r ? (~nm_ext + 1'b1) : nm_ext;
  assign res.den      = DEN_W'(dm_r);
  assign res.zero_den = flag_r;

endmodule

// ===== rtl/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rau_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import rau_pkg::*;

  // a result held back must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // flagged results carry a zero denominator
  a_flag_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[NUM_W +: DEN_W] == '0)
    else $error("zero_den set with nonzero denominator");

  // unflagged results carry a nonzero denominator
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[NUM_W +: DEN_W] != '0)
    else $error("zero denominator without zero_den");

  // the sequencer is busy right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous beat in progress");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
